@@ rtl/lpm_pkg.sv @@
package lpm_pkg;

  // Operation codes carried by an input transaction.
  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic        operation;
    logic [31:0] address;
    logic [31:0] prefix_mask;
    logic [31:0] hop_address;
    logic [7:0]  port_number;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_hop;
    logic [7:0]  found_port;
  } result_t;

  // Queue status seen by the walk engine.
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

@@ rtl/lpm_in_if.sv @@
interface lpm_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] address;
  logic [31:0] prefix_mask;
  logic [31:0] hop_address;
  logic [7:0]  port_number;

  modport source (output valid, operation, address, prefix_mask, hop_address, port_number,
                  input ready);
  modport sink (input valid, operation, address, prefix_mask, hop_address, port_number,
                output ready);
endinterface

@@ rtl/lpm_out_if.sv @@
interface lpm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] found_hop;
  logic [7:0]  found_port;

  modport source (output valid, status, found_hop, found_port, input ready);
  modport sink (input valid, status, found_hop, found_port, output ready);
endinterface

@@ rtl/binary_trie_longest_prefix_match.sv @@
// IPv4 longest-prefix-match routing table held as a binary trie.
// Input channel in_ch carries one transaction per request: operation 0 adds
// a route (address, prefix_mask, hop_address, port_number), operation 1
// looks up the best route for address. Output channel out_ch returns one
// transaction per request with status, found_hop and found_port.
// A request walks one trie level per cycle through the node store: it is
// dequeued, walks up to 33 levels (fewer for a short prefix or a lookup
// miss), has its route fetched and is passed to the output register. The
// node store's single read port sets that walk rate; requests are handled
// one at a time, and a two-entry queue in front takes new transactions while
// one is being walked. After reset the node store is cleared node by node,
// during which in_ch.ready stays low. The routing table is then empty.
// When the receiver holds out_ch.ready low, the result waits in the output
// register, the walk engine stops at its result state and the queue fills;
// in_ch.ready then drops.
module binary_trie_longest_prefix_match #(
  parameter int NODE_COUNT = 4096,
  parameter int PORT_BITS  = 8
) (
  input  logic      clk,
  input  logic      rst,
  lpm_in_if.sink    in_ch,
  lpm_out_if.source out_ch
);

  lpm_pkg::item_t       item;
  lpm_pkg::queue_head_t head;
  lpm_pkg::result_t     res;
  logic                 pop;
  logic                 enable;

  assign item.operation   = in_ch.operation;
  assign item.address     = in_ch.address;
  assign item.prefix_mask = in_ch.prefix_mask;
  assign item.hop_address = in_ch.hop_address;
  assign item.port_number = in_ch.port_number;

  lpm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .enable   (enable),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  (item),
    .head     (head),
    .pop      (pop)
  );

  lpm_back #(.NODE_COUNT(NODE_COUNT), .PORT_BITS(PORT_BITS)) u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .pop             (pop),
    .ready_for_items (enable),
    .res_valid       (out_ch.valid),
    .res_ready       (out_ch.ready),
    .res             (res)
  );

  assign out_ch.status     = res.status;
  assign out_ch.found_hop  = res.found_hop;
  assign out_ch.found_port = res.found_port;

endmodule

@@ rtl/lpm_ram.sv @@
module lpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/lpm_front.sv @@
module lpm_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 enable,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lpm_pkg::item_t       in_item,
  output lpm_pkg::queue_head_t head,
  input  logic                 pop
);

  lpm_pkg::item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       take;

  // Transactions are taken while there is room and the store is not being cleared.
  assign in_ready = enable && (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign take     = pop && (count != 2'd0);

  assign head.valid = (count != 2'd0);
  assign head.item  = slots[rd_ptr];

  // Two-entry queue between the input channel and the walk engine.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (take) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, take};
    end
  end

endmodule

@@ rtl/lpm_back.sv @@
module lpm_back #(
  parameter int NODE_COUNT = 4096,
  parameter int PORT_BITS  = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lpm_pkg::queue_head_t head,
  output logic                 pop,
  output logic                 ready_for_items,
  output logic                 res_valid,
  input  logic                 res_ready,
  output lpm_pkg::result_t     res
);

  localparam int IDXW  = $clog2(NODE_COUNT);
  localparam int LW    = 2 * IDXW + 1;
  localparam int PW    = (PORT_BITS < 8) ? PORT_BITS : 8;
  localparam int HW    = 32 + PW;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_RES   = 3'd4;

  logic [2:0]      state, state_next;
  logic [IDXW-1:0] clr_cnt;
  logic [IDXW-1:0] node, node_next;
  logic [IDXW:0]   next_free, next_free_next;
  logic [5:0]      lvl, lvl_next;
  logic [31:0]     addr_sh, addr_sh_next;
  logic [31:0]     mask_sh, mask_sh_next;
  logic            op;
  logic [31:0]     hop_in;
  logic [PW-1:0]   port_in;
  logic            have, have_next;
  logic [IDXW-1:0] best, best_next;
  logic [1:0]      status, status_next;

  logic            lk_we;
  logic [IDXW-1:0] lk_waddr;
  logic [LW-1:0]   lk_wdata;
  logic [LW-1:0]   lk_rdata;
  logic            hp_we;
  logic [HW-1:0]   hp_rdata;

  logic            w_valid;
  logic [IDXW-1:0] w_l1, w_l0, child;
  logic            dir, last;

  lpm_ram #(.WIDTH(LW), .DEPTH(NODE_COUNT)) u_links (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .raddr (node_next),
    .rdata (lk_rdata)
  );

  lpm_ram #(.WIDTH(HW), .DEPTH(NODE_COUNT)) u_routes (
    .clk   (clk),
    .we    (hp_we),
    .waddr (node),
    .wdata ({hop_in, port_in}),
    .raddr (best),
    .rdata (hp_rdata)
  );

  assign w_valid = lk_rdata[LW-1];
  assign w_l1    = lk_rdata[2*IDXW-1:IDXW];
  assign w_l0    = lk_rdata[IDXW-1:0];
  assign dir     = addr_sh[31];
  assign child   = dir ? w_l1 : w_l0;
  assign last    = lvl[5];

  assign ready_for_items = (state != S_CLEAR);
  assign pop             = (state == S_IDLE) && head.valid;

  // Walk sequencer: clears the node store after reset, then walks one trie level per cycle from the node store.
  always_comb begin
    state_next     = state;
    node_next      = node;
    next_free_next = next_free;
    lvl_next       = lvl;
    addr_sh_next   = addr_sh;
    mask_sh_next   = mask_sh;
    have_next      = have;
    best_next      = best;
    status_next    = status;
    lk_we          = 1'b0;
    lk_waddr       = node;
    lk_wdata       = lk_rdata;
    hp_we          = 1'b0;
    unique case (state)
      S_CLEAR: begin
        lk_we    = 1'b1;
        lk_waddr = clr_cnt;
        lk_wdata = '0;
        if (clr_cnt == IDXW'(NODE_COUNT - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        node_next = '0;
        lvl_next  = '0;
        have_next = 1'b0;
        best_next = '0;
        if (head.valid) begin
          addr_sh_next = head.item.address;
          mask_sh_next = head.item.prefix_mask;
          state_next   = S_WALK;
        end
      end
      S_WALK: begin
        if (op == lpm_pkg::OP_ADD) begin
          if (last || !mask_sh[31]) begin
            // Target node reached: store the route unless one is there.
            if (w_valid) begin
              status_next = lpm_pkg::ST_DUP;
            end else begin
              lk_we       = 1'b1;
              lk_wdata    = {1'b1, w_l1, w_l0};
              hp_we       = 1'b1;
              status_next = lpm_pkg::ST_OK;
            end
            state_next = S_FETCH;
          end else if (child == '0) begin
            if (next_free >= (IDXW+1)'(NODE_COUNT)) begin
              status_next = lpm_pkg::ST_FULL;
              state_next  = S_FETCH;
            end else begin
              // Link a fresh node; it was cleared, so its word reads empty.
              lk_we          = 1'b1;
              lk_wdata       = dir ? {w_valid, next_free[IDXW-1:0], w_l0}
                                   : {w_valid, w_l1, next_free[IDXW-1:0]};
              node_next      = next_free[IDXW-1:0];
              next_free_next = next_free + 1'b1;
              lvl_next       = lvl + 6'd1;
              addr_sh_next   = {addr_sh[30:0], 1'b0};
              mask_sh_next   = {mask_sh[30:0], 1'b0};
            end
          end else begin
            node_next    = child;
            lvl_next     = lvl + 6'd1;
            addr_sh_next = {addr_sh[30:0], 1'b0};
            mask_sh_next = {mask_sh[30:0], 1'b0};
          end
        end else begin
          if (w_valid) begin
            have_next = 1'b1;
            best_next = node;
          end
          if (last || child == '0) begin
            status_next = (have || w_valid) ? lpm_pkg::ST_OK : lpm_pkg::ST_NONE;
            state_next  = S_FETCH;
          end else begin
            node_next    = child;
            lvl_next     = lvl + 6'd1;
            addr_sh_next = {addr_sh[30:0], 1'b0};
          end
        end
      end
      S_FETCH: begin
        state_next = S_RES;
      end
      S_RES: begin
        if (!res_valid || res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    node    <= node_next;
    lvl     <= lvl_next;
    addr_sh <= addr_sh_next;
    mask_sh <= mask_sh_next;
    have    <= have_next;
    best    <= best_next;
    status  <= status_next;
    if (pop) begin
      op      <= head.item.operation;
      hop_in  <= head.item.hop_address;
      port_in <= head.item.port_number[PW-1:0];
    end
    if (state == S_RES && (!res_valid || res_ready)) begin
      res.status <= status;
      if (op == lpm_pkg::OP_LOOKUP && have) begin
        res.found_hop  <= hp_rdata[HW-1:PW];
        res.found_port <= 8'(hp_rdata[PW-1:0]);
      end else begin
        res.found_hop  <= '0;
        res.found_port <= '0;
      end
    end
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      next_free <= (IDXW+1)'(1);
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      next_free <= next_free_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      // Output register: filled from the result state, emptied by the receiver.
      if (state == S_RES && (!res_valid || res_ready)) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

@@ bench/tb_binary_trie_longest_prefix_match.sv @@
`timescale 1ns / 100ps

module tb_binary_trie_longest_prefix_match;

  localparam int NODES       = 4096;
  localparam int WATCH_LIMIT = 20000;
  localparam int RAND_ITEMS  = 930;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lpm_in_if  in_ch ();
  lpm_out_if out_ch ();

  binary_trie_longest_prefix_match dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  // Shadow routing table kept by the bench.
  logic [11:0] kid_tbl [NODES][2];
  logic        has_route [NODES];
  logic [31:0] hop_tbl [NODES];
  logic [7:0]  port_tbl [NODES];
  int          free_node;

  lpm_pkg::result_t pending_routes[$];
  lpm_pkg::item_t   prefix_pool[$];
  int               errors = 0;
  int               watch_count = 0;
  bit               calm = 1'b0;

  // Walks the shadow trie for one request and returns the answer it gives.
  function automatic lpm_pkg::result_t route_walk(lpm_pkg::item_t it);
    lpm_pkg::result_t r;
    int               node;
    int               best;
    int               b;
    logic             dir;
    r = '0;
    node = 0;
    best = -1;
    if (it.operation == lpm_pkg::OP_ADD) begin
      for (b = 31; b >= 0; b--) begin
        if (!it.prefix_mask[b]) break;
        dir = it.address[b];
        if (kid_tbl[node][dir] == 0) begin
          if (free_node >= NODES) begin
            r.status = lpm_pkg::ST_FULL;
            return r;
          end
          kid_tbl[node][dir] = free_node[11:0];
          free_node++;
        end
        node = kid_tbl[node][dir];
      end
      if (has_route[node]) begin
        r.status = lpm_pkg::ST_DUP;
      end else begin
        has_route[node] = 1'b1;
        hop_tbl[node] = it.hop_address;
        port_tbl[node] = it.port_number;
        r.status = lpm_pkg::ST_OK;
      end
    end else begin
      b = 31;
      forever begin
        if (has_route[node]) best = node;
        if (b < 0) break;
        node = kid_tbl[node][it.address[b]];
        if (node == 0) break;
        b--;
      end
      if (best >= 0) begin
        r.status = lpm_pkg::ST_OK;
        r.found_hop = hop_tbl[best];
        r.found_port = port_tbl[best];
      end else begin
        r.status = lpm_pkg::ST_NONE;
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] len_mask(int len);
    return (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
  endfunction

  // Presents one request and holds it until the block takes it.
  task automatic send_request(lpm_pkg::item_t it, bit typed, lpm_pkg::result_t typed_res);
    lpm_pkg::result_t r;
    while (!calm && $urandom_range(99) < 8) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= it.operation;
    in_ch.address     <= it.address;
    in_ch.prefix_mask <= it.prefix_mask;
    in_ch.hop_address <= it.hop_address;
    in_ch.port_number <= it.port_number;
    forever begin
      @(negedge clk);
      if (in_ch.ready) break;
    end
    @(posedge clk);
    r = route_walk(it);
    pending_routes.push_back(typed ? typed_res : r);
    if (it.operation == lpm_pkg::OP_ADD) prefix_pool.push_back(it);
  endtask

  // Receiver stalls.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= 8);
    end
  end

  // Result checking; sampled on the falling edge, taken at the next rising one.
  always @(negedge clk) begin
    lpm_pkg::result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_routes.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transaction: status %0d", out_ch.status);
      end else begin
        want = pending_routes.pop_front();
        if (out_ch.status !== want.status || out_ch.found_hop !== want.found_hop ||
            out_ch.found_port !== want.found_port) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected %0d/%h/%h, got %0d/%h/%h",
                     want.status, want.found_hop, want.found_port,
                     out_ch.status, out_ch.found_hop, out_ch.found_port);
        end
      end
    end
  end

  // Watchdog on cycles in which no transaction moves.
  always @(negedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      watch_count <= 0;
    end else if (watch_count >= WATCH_LIMIT) begin
      $display("timeout with no transaction");
      $display("== FAIL ==");
      $finish;
    end else begin
      watch_count <= watch_count + 1;
    end
  end

  typedef struct {
    lpm_pkg::item_t   it;
    bit               typed;
    lpm_pkg::result_t res;
  } row_t;

  row_t             plan [20];
  lpm_pkg::item_t   it;
  lpm_pkg::result_t none_res;
  lpm_pkg::result_t add_ok;
  lpm_pkg::result_t add_dup;
  int               pick;
  int               len;

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.operation <= lpm_pkg::OP_ADD;
    in_ch.address <= '0;
    in_ch.prefix_mask <= '0;
    in_ch.hop_address <= '0;
    in_ch.port_number <= '0;
    for (int n = 0; n < NODES; n++) begin
      kid_tbl[n][0] = '0;
      kid_tbl[n][1] = '0;
      has_route[n] = 1'b0;
    end
    free_node = 1;
    none_res = '0;
    add_ok = '{lpm_pkg::ST_OK, 32'h0, 8'h0};
    add_dup = '{lpm_pkg::ST_DUP, 32'h0, 8'h0};

    // Directed requests: empty table, default route, host routes at both extremes,
    // a non-contiguous mask, duplicates and nested prefixes.
    plan[0]  = '{'{lpm_pkg::OP_LOOKUP, 32'h0, 32'h0, 32'h0, 8'h0}, 1,
                 '{lpm_pkg::ST_NONE, 32'h0, 8'h0}};
    plan[1]  = '{'{lpm_pkg::OP_ADD, 32'h0, 32'h0, 32'hFFFF_FFFF, 8'hFF}, 1, add_ok};
    plan[2]  = '{'{lpm_pkg::OP_ADD, 32'h1234_5678, 32'h0, 32'h1, 8'h1}, 1, add_dup};
    plan[3]  = '{'{lpm_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 8'h0}, 1,
                 '{lpm_pkg::ST_OK, 32'hFFFF_FFFF, 8'hFF}};
    plan[4]  = '{'{lpm_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 8'h0}, 1, add_ok};
    plan[5]  = '{'{lpm_pkg::OP_ADD, 32'h0, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 8'h5A}, 1,
                 add_ok};
    plan[6]  = '{'{lpm_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 8'h0}, 1,
                 '{lpm_pkg::ST_OK, 32'h0, 8'h0}};
    plan[7]  = '{'{lpm_pkg::OP_LOOKUP, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF}, 1,
                 '{lpm_pkg::ST_OK, 32'hA5A5_A5A5, 8'h5A}};
    plan[8]  = '{'{lpm_pkg::OP_ADD, 32'h0A00_0000, 32'hFF00_FF00, 32'h1, 8'h1}, 1, add_ok};
    plan[9]  = '{'{lpm_pkg::OP_ADD, 32'h0A12_3456, 32'hFF00_0000, 32'h2, 8'h2}, 1, add_dup};
    plan[10] = '{'{lpm_pkg::OP_LOOKUP, 32'h0A00_00FF, 32'h0, 32'h0, 8'h0}, 0, none_res};
    plan[11] = '{'{lpm_pkg::OP_ADD, 32'hC0A8_0000, 32'hFFFF_0000, 32'h1234_5678, 8'h80}, 1,
                 add_ok};
    plan[12] = '{'{lpm_pkg::OP_ADD, 32'hC0A8_0100, 32'hFFFF_FF00, 32'h8765_4321, 8'h08}, 1,
                 add_ok};
    plan[13] = '{'{lpm_pkg::OP_LOOKUP, 32'hC0A8_01FE, 32'h0, 32'h0, 8'h0}, 0, none_res};
    plan[14] = '{'{lpm_pkg::OP_LOOKUP, 32'hC0A8_02FE, 32'h0, 32'h0, 8'h0}, 0, none_res};
    plan[15] = '{'{lpm_pkg::OP_ADD, 32'h8000_0000, 32'h8000_0000, 32'hDEAD_BEEF, 8'h7F}, 1,
                 add_ok};
    plan[16] = '{'{lpm_pkg::OP_LOOKUP, 32'h8F00_0000, 32'h0, 32'h0, 8'h0}, 0, none_res};
    plan[17] = '{'{lpm_pkg::OP_LOOKUP, 32'h7FFF_FFFF, 32'h0, 32'h0, 8'h0}, 0, none_res};
    plan[18] = '{'{lpm_pkg::OP_ADD, 32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'h5555_AAAA, 8'hC3}, 1,
                 add_ok};
    plan[19] = '{'{lpm_pkg::OP_LOOKUP, 32'h7FFF_FFFE, 32'h0, 32'h0, 8'h0}, 0, none_res};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[k]) send_request(plan[k].it, plan[k].typed, plan[k].res);

    // Random traffic: mostly routes built on earlier prefixes and lookups
    // near them, ending with host routes that exhaust the node store.
    for (int i = 0; i < RAND_ITEMS; i++) begin
      calm = (i >= 200 && i < 350);
      if (i == 400) begin
        in_ch.valid <= 1'b0;
        while (pending_routes.size() != 0) @(posedge clk);
      end
      it.hop_address = $urandom;
      it.port_number = $urandom_range(255);
      it.prefix_mask = $urandom;
      pick = $urandom_range(99);
      if (i >= 650) begin
        it.operation = (pick < 60) ? lpm_pkg::OP_ADD : lpm_pkg::OP_LOOKUP;
        it.address = $urandom;
        it.prefix_mask = (pick < 55) ? 32'hFFFF_FFFF : len_mask($urandom_range(32));
      end else if (pick < 10 && prefix_pool.size() != 0) begin
        it = prefix_pool[$urandom_range(prefix_pool.size() - 1)];
        it.hop_address = $urandom;
      end else if (pick < 45) begin
        it.operation = lpm_pkg::OP_ADD;
        len = ($urandom_range(9) == 0) ? $urandom_range(32) : $urandom_range(24);
        it.address = $urandom;
        if (prefix_pool.size() != 0 && $urandom_range(1))
          it.address = (prefix_pool[$urandom_range(prefix_pool.size() - 1)].address
                        & 32'hFFF0_0000) | (it.address & 32'h000F_FFFF);
        // Lower mask bits are random now and then, to exercise broken masks.
        if ($urandom_range(3) != 0) it.prefix_mask = len_mask(len);
        else it.prefix_mask = len_mask(len) | ($urandom & ~len_mask(len));
      end else begin
        it.operation = lpm_pkg::OP_LOOKUP;
        it.address = $urandom;
        if (prefix_pool.size() != 0 && pick < 85)
          it.address = (prefix_pool[$urandom_range(prefix_pool.size() - 1)].address
                        & len_mask($urandom_range(32))) | ($urandom & 32'h0000_0FFF);
      end
      send_request(it, 0, none_res);
    end
    in_ch.valid <= 1'b0;
    calm = 1'b0;

    while (pending_routes.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/lpm_pkg.sv
rtl/lpm_in_if.sv
rtl/lpm_out_if.sv
rtl/lpm_ram.sv
rtl/lpm_front.sv
rtl/lpm_back.sv
rtl/binary_trie_longest_prefix_match.sv
bench/tb_binary_trie_longest_prefix_match.sv
